>>> design/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Types, constants and chunk sizing helpers shared by the chunked bump
// allocator modules.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int unsigned MaxChunks         = 16;
  localparam int unsigned AlignBytes        = 8;
  localparam int unsigned MaxChunkBytes     = 1048576;
  localparam int unsigned DefaultChunkBytes = 4096;
  localparam int unsigned GrowthCap         = 4;

  localparam int unsigned IdxW      = 4;
  localparam int unsigned FillW     = 21;
  localparam int unsigned SumW      = 25;
  localparam int unsigned ChunkCntW = 5;
  localparam int unsigned ReqW      = 32;
  localparam int unsigned AlignedW  = ReqW + 1;
  localparam int unsigned CntW      = 32;
  localparam int unsigned BytesW    = 48;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 21;

  localparam logic [CfgIdxW-1:0] CFG_BASE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESET   = 2'd1,
    OP_MARK    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FALLBACK = 3'd1,
    ST_LIMIT    = 3'd2,
    ST_ZERO     = 3'd3,
    ST_BAD_MARK = 3'd4
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [ReqW-1:0]   request_bytes;
    logic [IdxW-1:0]   mark_chunk;
    logic [FillW-1:0]  mark_offset;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [IdxW-1:0]      chunk_index;
    logic [FillW-1:0]     offset;
    logic [SumW-1:0]      used_bytes;
    logic [SumW-1:0]      capacity_bytes;
    logic [ChunkCntW-1:0] chunks_made;
    logic [CntW-1:0]      allocs_done;
    logic [CntW-1:0]      fallbacks_done;
    logic [CntW-1:0]      resets_done;
    logic [BytesW-1:0]    bytes_out;
  } out_t;

  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  raddr;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [FillW-1:0] wdata;
    logic             clr_all;
    logic             clr_above;
    logic [IdxW-1:0]  clr_idx;
  } mem_req_t;

  function automatic logic [FillW-1:0] eff_base(logic [FillW-1:0] b);
    if (b == '0) return FillW'(DefaultChunkBytes);
    if (b > FillW'(MaxChunkBytes)) return FillW'(MaxChunkBytes);
    return b;
  endfunction

  // base << min(idx, 4), capped at the largest chunk
  function automatic logic [FillW-1:0] chunk_span(logic [FillW-1:0] eff,
                                                  logic [IdxW-1:0]  idx);
    logic [SumW-1:0] s;
    logic [2:0]      sh;
    sh = (idx > IdxW'(GrowthCap)) ? 3'(GrowthCap) : idx[2:0];
    s  = SumW'(eff) << sh;
    return (s > SumW'(MaxChunkBytes)) ? FillW'(MaxChunkBytes) : s[FillW-1:0];
  endfunction

endpackage

>>> design/cba_fill_mem.sv
// ----------------------------------------------------------------------------
// cba_fill_mem
// Per-chunk fill level store: one write and one registered read a cycle,
// with per-entry valid bits so that bulk clears take effect at once.
// ----------------------------------------------------------------------------
module cba_fill_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cba_pkg::mem_req_t             req_i,
  output logic [cba_pkg::FillW-1:0]     rdata_o
);

  logic [cba_pkg::FillW-1:0]     fill_mem [cba_pkg::MaxChunks];
  logic [cba_pkg::MaxChunks-1:0] vld_q, vld_d;
  logic [cba_pkg::FillW-1:0]     rdata_q;
  logic                          rvld_q;

  always_comb begin
    vld_d = vld_q;
    if (req_i.clr_all) begin
      vld_d = '0;
    end else begin
      for (int i = 0; i < cba_pkg::MaxChunks; i++) begin
        if (req_i.clr_above && (cba_pkg::IdxW'(i) > req_i.clr_idx)) begin
          vld_d[i] = 1'b0;
        end
      end
      if (req_i.we) begin
        vld_d[req_i.waddr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      fill_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= fill_mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // an entry not written since its last clear reads as empty
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> design/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl
// Sequencer for the allocator: decodes each item, reads the fill store,
// updates position and statistics, and walks the table on a release to an earlier chunk.
// ----------------------------------------------------------------------------
module cba_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cba_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cba_pkg::in_t                    in_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output cba_pkg::out_t                   res_o,
  output cba_pkg::mem_req_t               mem_req_o,
  input  logic [cba_pkg::FillW-1:0]       mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_e;

  state_e state_q, state_d;

  logic [cba_pkg::FillW-1:0]     base_q, base_d;
  logic [cba_pkg::ChunkCntW-1:0] limit_q, limit_d;
  logic [cba_pkg::IdxW-1:0]      active_q, active_d;
  logic [cba_pkg::ChunkCntW-1:0] created_q, created_d;
  logic [cba_pkg::SumW-1:0]      used_q, used_d;
  logic [cba_pkg::SumW-1:0]      cap_q, cap_d;
  logic [cba_pkg::CntW-1:0]      alloc_cnt_q, alloc_cnt_d;
  logic [cba_pkg::CntW-1:0]      fb_cnt_q, fb_cnt_d;
  logic [cba_pkg::CntW-1:0]      rst_cnt_q, rst_cnt_d;
  logic [cba_pkg::BytesW-1:0]    bytes_q, bytes_d;
  logic [cba_pkg::IdxW-1:0]      walk_idx_q, walk_idx_d;
  logic [cba_pkg::SumW-1:0]      acc_q, acc_d;

  cba_pkg::op_e                  op_q;
  logic                          zero_q;
  logic [cba_pkg::AlignedW-1:0]  aligned_q;
  logic [cba_pkg::IdxW-1:0]      mchunk_q;
  logic [cba_pkg::FillW-1:0]     moff_q;

  logic                          accept;
  logic [cba_pkg::AlignedW-1:0]  aligned_in;
  logic [cba_pkg::FillW-1:0]     eff;
  logic [cba_pkg::FillW-1:0]     size_a, size_nx, size_m, clamp;
  logic [cba_pkg::ChunkCntW-1:0] nx, limit_eff;
  logic [cba_pkg::FillW:0]       bump;
  logic                          fits, fallback, bad_mark;
  logic [cba_pkg::SumW-1:0]      fill_ext, acc_sub, rel_base, rel_used;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign aligned_in = ({1'b0, in_i.request_bytes} + cba_pkg::AlignedW'(cba_pkg::AlignBytes - 1))
                    & ~cba_pkg::AlignedW'(cba_pkg::AlignBytes - 1);

  assign eff       = cba_pkg::eff_base(base_q);
  assign nx        = cba_pkg::ChunkCntW'(active_q) + 1'b1;
  assign size_a    = cba_pkg::chunk_span(eff, active_q);
  assign size_nx   = cba_pkg::chunk_span(eff, nx[cba_pkg::IdxW-1:0]);
  assign size_m    = cba_pkg::chunk_span(eff, mchunk_q);
  assign clamp     = (moff_q > size_m) ? size_m : moff_q;
  assign limit_eff = (limit_q == '0 || limit_q > cba_pkg::ChunkCntW'(cba_pkg::MaxChunks))
                   ? cba_pkg::ChunkCntW'(cba_pkg::MaxChunks) : limit_q;

  assign fallback = aligned_q > cba_pkg::AlignedW'(eff >> 1);
  assign bump     = {1'b0, mem_rdata_i} + {1'b0, aligned_q[cba_pkg::FillW-1:0]};
  assign fits     = bump <= {1'b0, size_a};
  assign bad_mark = cba_pkg::ChunkCntW'(mchunk_q) >= created_q;

  // chunks past the active one are always empty, so a release only has to
  // take back the fills from the mark up to the active chunk
  assign fill_ext = cba_pkg::SumW'(mem_rdata_i);
  assign acc_sub  = ((state_q == S_WALK) ? acc_q : used_q) - fill_ext;
  assign rel_base = (state_q == S_EXEC && mchunk_q > active_q) ? used_q : acc_sub;
  assign rel_used = rel_base + cba_pkg::SumW'(clamp);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    limit_d     = limit_q;
    active_d    = active_q;
    created_d   = created_q;
    used_d      = used_q;
    cap_d       = cap_q;
    alloc_cnt_d = alloc_cnt_q;
    fb_cnt_d    = fb_cnt_q;
    rst_cnt_d   = rst_cnt_q;
    bytes_d     = bytes_q;
    walk_idx_d  = walk_idx_q;
    acc_d       = acc_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = cba_pkg::ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d         = S_EXEC;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.raddr = (in_i.operation == cba_pkg::OP_RELEASE)
                          ? in_i.mark_chunk : active_q;
        end
      end
      S_EXEC: begin
        if (op_q == cba_pkg::OP_RELEASE && !bad_mark && mchunk_q < active_q) begin
          state_d         = S_WALK;
          acc_d           = acc_sub;
          walk_idx_d      = mchunk_q + 1'b1;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.raddr = mchunk_q + 1'b1;
        end else if (res_ready_i) begin
          state_d     = S_IDLE;
          res_valid_o = 1'b1;
          unique case (op_q)
            cba_pkg::OP_ALLOC: begin
              if (zero_q) begin
                res_o.status = cba_pkg::ST_ZERO;
              end else if (fallback) begin
                res_o.status = cba_pkg::ST_FALLBACK;
                fb_cnt_d     = fb_cnt_q + 1'b1;
                alloc_cnt_d  = alloc_cnt_q + 1'b1;
                bytes_d      = bytes_q + cba_pkg::BytesW'(aligned_q);
              end else if (fits) begin
                res_o.chunk_index = active_q;
                res_o.offset      = mem_rdata_i;
                mem_req_o.we      = 1'b1;
                mem_req_o.waddr   = active_q;
                mem_req_o.wdata   = bump[cba_pkg::FillW-1:0];
                used_d            = used_q + cba_pkg::SumW'(aligned_q[cba_pkg::FillW-1:0]);
                alloc_cnt_d       = alloc_cnt_q + 1'b1;
                bytes_d           = bytes_q + cba_pkg::BytesW'(aligned_q);
              end else if (nx >= cba_pkg::ChunkCntW'(cba_pkg::MaxChunks) ||
                           (nx >= created_q && created_q >= limit_eff)) begin
                res_o.status = cba_pkg::ST_LIMIT;
              end else begin
                if (nx >= created_q) begin
                  created_d = nx + 1'b1;
                  cap_d     = cap_q + cba_pkg::SumW'(size_nx);
                end
                active_d          = nx[cba_pkg::IdxW-1:0];
                res_o.chunk_index = nx[cba_pkg::IdxW-1:0];
                res_o.offset      = '0;
                mem_req_o.we      = 1'b1;
                mem_req_o.waddr   = nx[cba_pkg::IdxW-1:0];
                mem_req_o.wdata   = aligned_q[cba_pkg::FillW-1:0];
                used_d            = used_q + cba_pkg::SumW'(aligned_q[cba_pkg::FillW-1:0]);
                alloc_cnt_d       = alloc_cnt_q + 1'b1;
                bytes_d           = bytes_q + cba_pkg::BytesW'(aligned_q);
              end
            end
            cba_pkg::OP_RESET: begin
              mem_req_o.clr_all = 1'b1;
              active_d          = '0;
              used_d            = '0;
              rst_cnt_d         = rst_cnt_q + 1'b1;
            end
            cba_pkg::OP_MARK: begin
              res_o.chunk_index = active_q;
              res_o.offset      = mem_rdata_i;
            end
            cba_pkg::OP_RELEASE: begin
              if (bad_mark) begin
                res_o.status = cba_pkg::ST_BAD_MARK;
              end else begin
                mem_req_o.we        = 1'b1;
                mem_req_o.waddr     = mchunk_q;
                mem_req_o.wdata     = clamp;
                mem_req_o.clr_above = 1'b1;
                mem_req_o.clr_idx   = mchunk_q;
                active_d            = mchunk_q;
                used_d              = rel_used;
                res_o.chunk_index   = mchunk_q;
                res_o.offset        = clamp;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_idx_q != active_q) begin
          acc_d           = acc_sub;
          walk_idx_d      = walk_idx_q + 1'b1;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.raddr = walk_idx_q + 1'b1;
        end else if (res_ready_i) begin
          state_d             = S_IDLE;
          res_valid_o         = 1'b1;
          mem_req_o.we        = 1'b1;
          mem_req_o.waddr     = mchunk_q;
          mem_req_o.wdata     = clamp;
          mem_req_o.clr_above = 1'b1;
          mem_req_o.clr_idx   = mchunk_q;
          active_d            = mchunk_q;
          used_d              = rel_used;
          res_o.chunk_index   = mchunk_q;
          res_o.offset        = clamp;
        end
      end
      default: state_d = S_IDLE;
    endcase

    res_o.used_bytes     = used_d;
    res_o.capacity_bytes = cap_d;
    res_o.chunks_made    = created_d;
    res_o.allocs_done    = alloc_cnt_d;
    res_o.fallbacks_done = fb_cnt_d;
    res_o.resets_done    = rst_cnt_d;
    res_o.bytes_out      = bytes_d;

    // base write rebuilds the chunk table; counters survive
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cba_pkg::CFG_BASE: begin
          base_d            = cfg_data_i;
          mem_req_o.clr_all = 1'b1;
          active_d          = '0;
          created_d         = cba_pkg::ChunkCntW'(1);
          used_d            = '0;
          cap_d             = cba_pkg::SumW'(cba_pkg::chunk_span(
                                cba_pkg::eff_base(cfg_data_i), '0));
        end
        cba_pkg::CFG_LIMIT: begin
          limit_d = cfg_data_i[cba_pkg::ChunkCntW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= cba_pkg::FillW'(cba_pkg::DefaultChunkBytes);
      limit_q     <= '0;
      active_q    <= '0;
      created_q   <= cba_pkg::ChunkCntW'(1);
      used_q      <= '0;
      cap_q       <= cba_pkg::SumW'(cba_pkg::DefaultChunkBytes);
      alloc_cnt_q <= '0;
      fb_cnt_q    <= '0;
      rst_cnt_q   <= '0;
      bytes_q     <= '0;
      walk_idx_q  <= '0;
      acc_q       <= '0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      limit_q     <= limit_d;
      active_q    <= active_d;
      created_q   <= created_d;
      used_q      <= used_d;
      cap_q       <= cap_d;
      alloc_cnt_q <= alloc_cnt_d;
      fb_cnt_q    <= fb_cnt_d;
      rst_cnt_q   <= rst_cnt_d;
      bytes_q     <= bytes_d;
      walk_idx_q  <= walk_idx_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_i.operation;
      zero_q    <= (in_i.request_bytes == '0);
      aligned_q <= aligned_in;
      mchunk_q  <= in_i.mark_chunk;
      moff_q    <= in_i.mark_offset;
    end
  end

`ifndef NO_ASSERTIONS
  a_used_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= cap_q)
    else $error("fill total above capacity");

  a_active_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cba_pkg::ChunkCntW'(active_q) < created_q)
    else $error("active chunk not created");

  a_created_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    created_q != '0 && created_q <= cba_pkg::ChunkCntW'(cba_pkg::MaxChunks))
    else $error("chunk count out of range");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> (walk_idx_q <= active_q && walk_idx_q > mchunk_q))
    else $error("release walk outside mark..active");

  a_res_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_ready_i && state_q != S_IDLE))
    else $error("result issued without room");
`endif

endmodule

>>> design/chunked_bump_allocator.sv
// ----------------------------------------------------------------------------
// chunked_bump_allocator
// Multi-chunk bump allocator with alloc, reset, mark and release items.
// ----------------------------------------------------------------------------
// Items arrive on in_valid_i/in_stall_o/in_i and each gives exactly one
// result on out_valid_o/out_stall_i/out_o, in order. Transfer happens on a
// clock edge with valid high and stall low.
// An item is accepted at the end of an idle cycle that also reads its fill
// entry; its result is then written into the output register once that
// register is free. A release to chunk m below the active chunk a first
// walks the entries above m up to a, one fill read per chunk. An item is
// taken in only while the sequencer is idle, one item at a time.
// A stalled result is held in the output register while the next item is
// taken in; that item then waits to complete until the register frees.
// The user must write configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only
// while idle; the block does not enforce it. Index 0 sets the base chunk size
// and empties the chunk table, index 1 sets the chunk limit.
// Reset (rst_ni low) empties all chunks at once, leaves one chunk of 4096
// bytes, base 4096, no limit and all counters zero; no clearing pass.
// ----------------------------------------------------------------------------
module chunked_bump_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cba_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cba_pkg::in_t                 in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cba_pkg::out_t                out_o
);

  cba_pkg::mem_req_t          mem_req;
  logic [cba_pkg::FillW-1:0]  mem_rdata;
  logic                       res_valid;
  logic                       res_ready;
  cba_pkg::out_t              res;

  logic                       out_valid_q, out_valid_d;
  cba_pkg::out_t              out_q;

  cba_fill_mem u_fill_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  cba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> dv/tb_chunked_bump_allocator.sv
// ----------------------------------------------------------------------------
// tb_chunked_bump_allocator
// Self-checking bench for the chunked bump allocator. A short table of
// directed items (extremes, error codes, chunk growth, limits, rewinds) is
// followed by random phases under different base sizes and chunk limits,
// each with one of four sender/receiver idling mixes. Every result is
// checked field by field against an in-bench arena model, in order.
// ----------------------------------------------------------------------------
module tb_chunked_bump_allocator;
  import cba_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 225;
  localparam int unsigned SettleGap   = 24;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    in_t                 item;
    bit                  typed;
    status_e             st;
    logic [IdxW-1:0]     idx;
    logic [FillW-1:0]    off;
  } step_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_item;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned faults    = 0;
  int unsigned cycles    = 0;

  // arena model
  logic [FillW-1:0]    fill_q [MaxChunks];
  int unsigned         at_chunk;
  int unsigned         made_chunks;
  logic [SumW-1:0]     cap_sum;
  logic [CntW-1:0]     n_alloc, n_fallback, n_reset;
  logic [BytesW-1:0]   n_bytes;
  logic [CfgDataW-1:0] base_reg;
  logic [4:0]          limit_reg;

  out_t  replies_due [$];
  step_t plan [$];

  logic [CfgDataW-1:0] phase_base  [8] = '{16, 1048576, 1, 64, 21'h1FFFFF, 24, 256, 0};
  logic [CfgDataW-1:0] phase_limit [8] = '{0, 0, 1, 3, 16, 31, 5, 2};

  chunked_bump_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned base_now();
    if (base_reg == 0) return DefaultChunkBytes;
    if (base_reg > MaxChunkBytes) return MaxChunkBytes;
    return base_reg;
  endfunction

  function automatic longint unsigned chunk_bytes(int unsigned i);
    longint unsigned s;
    s = base_now() << ((i > GrowthCap) ? GrowthCap : i);
    return (s > MaxChunkBytes) ? MaxChunkBytes : s;
  endfunction

  function automatic int unsigned limit_now();
    return (limit_reg == 0 || limit_reg > MaxChunks) ? MaxChunks : limit_reg;
  endfunction

  function automatic void empty_table();
    foreach (fill_q[i]) fill_q[i] = '0;
    at_chunk    = 0;
    made_chunks = 1;
    cap_sum     = SumW'(chunk_bytes(0));
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    if (idx == CFG_BASE) begin
      base_reg = val;
      empty_table();
    end else begin
      limit_reg = val[4:0];
    end
  endfunction

  function automatic out_t arena_step(input in_t it);
    out_t            r;
    longint unsigned need;
    logic [SumW-1:0] used;
    int unsigned     a;
    bit              fits;
    r = '0;
    r.status = ST_OK;
    case (it.operation)
      OP_ALLOC: begin
        need = 64'(it.request_bytes) + AlignBytes - 1;
        need = need / AlignBytes * AlignBytes;
        if (it.request_bytes == 0) begin
          r.status = ST_ZERO;
        end else if (need > base_now() / 2) begin
          r.status   = ST_FALLBACK;
          n_fallback = n_fallback + 1;
          n_alloc    = n_alloc + 1;
          n_bytes    = n_bytes + BytesW'(need);
        end else begin
          a    = at_chunk;
          fits = 1'b1;
          if (fill_q[a] + need > chunk_bytes(a)) begin
            if (a + 1 < made_chunks && a + 1 < MaxChunks) begin
              a++;
            end else if (made_chunks >= limit_now() || a + 1 >= MaxChunks) begin
              fits = 1'b0;
            end else begin
              a++;
              made_chunks = a + 1;
              fill_q[a]   = '0;
              cap_sum     = cap_sum + SumW'(chunk_bytes(a));
            end
          end
          if (fits) begin
            at_chunk      = a;
            r.chunk_index = IdxW'(a);
            r.offset      = fill_q[a];
            fill_q[a]     = fill_q[a] + FillW'(need);
            n_alloc       = n_alloc + 1;
            n_bytes       = n_bytes + BytesW'(need);
          end else begin
            r.status = ST_LIMIT;
          end
        end
      end
      OP_RESET: begin
        foreach (fill_q[i]) fill_q[i] = '0;
        at_chunk = 0;
        n_reset  = n_reset + 1;
      end
      OP_MARK: begin
        r.chunk_index = IdxW'(at_chunk);
        r.offset      = fill_q[at_chunk];
      end
      default: begin
        a = it.mark_chunk;
        if (a >= made_chunks) begin
          r.status = ST_BAD_MARK;
        end else begin
          fill_q[a] = (it.mark_offset > chunk_bytes(a)) ? FillW'(chunk_bytes(a))
                                                        : it.mark_offset;
          for (int i = a + 1; i < MaxChunks; i++) fill_q[i] = '0;
          at_chunk      = a;
          r.chunk_index = IdxW'(a);
          r.offset      = fill_q[a];
        end
      end
    endcase
    used = '0;
    foreach (fill_q[i]) used = used + SumW'(fill_q[i]);
    r.used_bytes     = used;
    r.capacity_bytes = cap_sum;
    r.chunks_made    = ChunkCntW'(made_chunks);
    r.allocs_done    = n_alloc;
    r.fallbacks_done = n_fallback;
    r.resets_done    = n_reset;
    r.bytes_out      = n_bytes;
    return r;
  endfunction

  function automatic in_t mk_item(op_e op, logic [ReqW-1:0] req,
                                  logic [IdxW-1:0] mc, logic [FillW-1:0] mo);
    in_t it;
    it.operation     = op;
    it.request_bytes = req;
    it.mark_chunk    = mc;
    it.mark_offset   = mo;
    return it;
  endfunction

  function automatic void plan_op(op_e op, logic [ReqW-1:0] req, logic [IdxW-1:0] mc,
                                  logic [FillW-1:0] mo, bit typed = 1'b0,
                                  status_e st = ST_OK, logic [IdxW-1:0] idx = '0,
                                  logic [FillW-1:0] off = '0);
    step_t s;
    s.is_cfg  = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.item    = mk_item(op, req, mc, mo);
    s.typed   = typed;
    s.st      = st;
    s.idx     = idx;
    s.off     = off;
    plan.push_back(s);
  endfunction

  function automatic void plan_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    step_t s;
    s         = '{default: '0, st: ST_OK, item: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    plan.push_back(s);
  endfunction

  function automatic in_t draw_item();
    in_t         it;
    int unsigned pick, h, mc;
    it = mk_item(OP_ALLOC, $urandom(), IdxW'($urandom()), FillW'($urandom()));
    h    = 32'(base_now() / 2);
    pick = $urandom_range(99);
    if (pick < 70) begin
      pick = $urandom_range(99);
      if (pick < 3) it.request_bytes = '0;
      else if (pick < 9) it.request_bytes = $urandom();
      else if (pick < 16) it.request_bytes = h + $urandom_range(64, 1);
      else if (pick < 40) it.request_bytes = $urandom_range(h, h / 2);
      else it.request_bytes = $urandom_range((h >= 64) ? h / 8 : ((h > 0) ? h : 1), 1);
    end else if (pick < 80) begin
      it.operation = OP_MARK;
    end else if (pick < 95) begin
      it.operation = OP_RELEASE;
      mc = ($urandom_range(99) < 85) ? $urandom_range(made_chunks - 1, 0)
                                     : $urandom_range(MaxChunks - 1, 0);
      it.mark_chunk = IdxW'(mc);
      if ($urandom_range(99) < 70)
        it.mark_offset = FillW'($urandom_range(32'(chunk_bytes(mc)), 0));
    end else begin
      it.operation = OP_RESET;
    end
    return it;
  endfunction

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic push_item(input in_t it, input bit typed = 1'b0,
                           input status_e st = ST_OK, input logic [IdxW-1:0] idx = '0,
                           input logic [FillW-1:0] off = '0);
    out_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = arena_step(it);
    if (typed) begin
      r.status      = st;
      r.chunk_index = idx;
      r.offset      = off;
    end
    replies_due.push_back(r);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SettleGap) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    apply_reg(idx, val);
  endtask

  task automatic note_fault(input string what, input logic [63:0] e, input logic [63:0] a);
    faults++;
    if (faults <= 10) $display("mismatch %s: expected %0h, got %0h", what, e, a);
  endtask

  task automatic check_field(input string what, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) note_fault(what, e, a);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_replies
    out_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        note_fault("unexpected result", '0, 64'(out_item.status));
      end else begin
        due = replies_due.pop_front();
        check_field("status", 64'(due.status), 64'(out_item.status));
        check_field("chunk_index", 64'(due.chunk_index), 64'(out_item.chunk_index));
        check_field("offset", 64'(due.offset), 64'(out_item.offset));
        check_field("used_bytes", 64'(due.used_bytes), 64'(out_item.used_bytes));
        check_field("capacity_bytes", 64'(due.capacity_bytes),
                    64'(out_item.capacity_bytes));
        check_field("chunks_made", 64'(due.chunks_made), 64'(out_item.chunks_made));
        check_field("allocs_done", 64'(due.allocs_done), 64'(out_item.allocs_done));
        check_field("fallbacks_done", 64'(due.fallbacks_done),
                    64'(out_item.fallbacks_done));
        check_field("resets_done", 64'(due.resets_done), 64'(out_item.resets_done));
        check_field("bytes_out", 64'(due.bytes_out), 64'(out_item.bytes_out));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [CfgDataW-1:0] base_val;
    base_reg   = CfgDataW'(DefaultChunkBytes);
    limit_reg  = '0;
    n_alloc    = '0;
    n_fallback = '0;
    n_reset    = '0;
    n_bytes    = '0;
    empty_table();

    // power-up defaults: base 4096, no limit
    plan_op(OP_MARK,    0,            0,  0, 1, ST_OK,       0, 0);
    plan_op(OP_ALLOC,   0,            0,  0, 1, ST_ZERO,     0, 0);
    plan_op(OP_ALLOC,   1,            0,  0, 1, ST_OK,       0, 0);
    plan_op(OP_ALLOC,   32'hFFFFFFFF, 0,  0, 1, ST_FALLBACK, 0, 0);
    plan_op(OP_ALLOC,   2048,         0,  0, 1, ST_OK,       0, 8);
    plan_op(OP_ALLOC,   2049,         0,  0, 1, ST_FALLBACK, 0, 0);
    plan_op(OP_RELEASE, 0,            15, 0, 1, ST_BAD_MARK, 0, 0);
    plan_op(OP_RELEASE, 0,            0,  21'h1FFFFF, 1, ST_OK, 0, 4096);
    plan_op(OP_ALLOC,   8,            0,  0, 1, ST_OK,       1, 0);
    plan_op(OP_MARK,    0,            0,  0, 1, ST_OK,       1, 8);
    plan_op(OP_RESET,   32'hFFFFFFFF, 15, 21'h1FFFFF, 1, ST_OK, 0, 0);
    // tiny chunks and a limit of two
    plan_reg(CFG_BASE, 16);
    plan_reg(CFG_LIMIT, 2);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_ALLOC,   5, 0, 0, 1, ST_OK, 0, 8);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_ALLOC,   1, 0, 0, 1, ST_LIMIT, 0, 0);
    plan_op(OP_RELEASE, 0, 0, 12);
    plan_op(OP_ALLOC,   8, 0, 0);
    plan_op(OP_RELEASE, 0, 2, 0, 1, ST_BAD_MARK, 0, 0);
    // largest chunks, then the default base with a limit of one
    plan_reg(CFG_BASE, 1048576);
    plan_reg(CFG_LIMIT, 31);
    plan_op(OP_ALLOC, 524288, 0, 0, 1, ST_OK, 0, 0);
    plan_op(OP_ALLOC, 524289, 0, 0, 1, ST_FALLBACK, 0, 0);
    plan_reg(CFG_BASE, 21'h1FFFFF);
    plan_reg(CFG_BASE, 0);
    plan_reg(CFG_LIMIT, 1);
    plan_op(OP_ALLOC, 2048, 0, 0);
    plan_op(OP_ALLOC, 2048, 0, 0);
    plan_op(OP_ALLOC, 8,    0, 0, 1, ST_LIMIT, 0, 0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct   = 27;
    stall_pct = 27;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].st, plan[i].idx, plan[i].off);
      end
    end
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      base_val = (ph == 6) ? CfgDataW'($urandom_range(3000, 17)) : phase_base[ph];
      write_reg(CFG_BASE, base_val);
      write_reg(CFG_LIMIT, phase_limit[ph]);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 84; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 84; end
        default: begin gap_pct = 27; stall_pct = 27; end
      endcase
      repeat (PhaseItems) push_item(draw_item());
      settle();
    end

    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/cba_pkg.sv
design/cba_fill_mem.sv
design/cba_ctrl.sv
design/chunked_bump_allocator.sv
dv/tb_chunked_bump_allocator.sv
